// ===== sv/ialu_pkg.sv =====
// shared widths, operation and status codes, and controller/datapath structs
package ialu_pkg;

  localparam int unsigned W     = 32;
  localparam int unsigned CNT_W = $clog2(W);

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_POW = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_BAD_OP   = 2'd2;
  localparam logic [1:0] ST_NEG_EXP  = 2'd3;

  typedef struct packed {
    logic load;
    logic div_step;
    logic pow_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       err;
    logic       exp_zero;
  } stat_t;

endpackage

// ===== sv/ialu_dp.sv =====
// datapath: operand registers, serial divider step, square-and-multiply step
module ialu_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ialu_pkg::cmd_t            cmd_i,
  input  logic [2:0]                kind_i,
  input  logic [ialu_pkg::W-1:0]    operand_a_i,
  input  logic [ialu_pkg::W-1:0]    operand_b_i,
  output ialu_pkg::stat_t           stat_o,
  output logic [ialu_pkg::W-1:0]    result_o,
  output logic [1:0]                status_o
);

  logic [2:0]               kind_q;
  logic [ialu_pkg::W-1:0]   a_q, b_q, w_q, d_q, r_q, res_q;
  logic                     neg_q;
  logic [1:0]               st_q, st_d;

  logic [ialu_pkg::W-1:0]   abs_a, abs_b, rs;
  logic [ialu_pkg::W:0]     diff;
  logic                     ge;
  logic [2*ialu_pkg::W-1:0] p_acc, p_sq;
  logic [ialu_pkg::W-1:0]   fin_res;

  assign abs_a = operand_a_i[ialu_pkg::W-1] ? (~operand_a_i + 1'b1) : operand_a_i;
  assign abs_b = operand_b_i[ialu_pkg::W-1] ? (~operand_b_i + 1'b1) : operand_b_i;

  assign rs   = {r_q[ialu_pkg::W-2:0], w_q[ialu_pkg::W-1]};
  assign diff = {1'b0, rs} - {1'b0, d_q};
  assign ge   = ~diff[ialu_pkg::W];

  assign p_acc = r_q * a_q;
  assign p_sq  = a_q * a_q;

  always_comb begin
    unique case (kind_i)
      ialu_pkg::KIND_ADD,
      ialu_pkg::KIND_SUB,
      ialu_pkg::KIND_MUL: st_d = ialu_pkg::ST_OK;
      ialu_pkg::KIND_DIV: st_d = (operand_b_i == '0) ? ialu_pkg::ST_DIV_ZERO : ialu_pkg::ST_OK;
      ialu_pkg::KIND_POW: st_d = operand_b_i[ialu_pkg::W-1] ? ialu_pkg::ST_NEG_EXP
                                                           : ialu_pkg::ST_OK;
      default:            st_d = ialu_pkg::ST_BAD_OP;
    endcase
  end

  always_comb begin
    if (st_q != ialu_pkg::ST_OK) begin
      fin_res = '0;
    end else begin
      unique case (kind_q)
        ialu_pkg::KIND_ADD: fin_res = a_q + b_q;
        ialu_pkg::KIND_SUB: fin_res = a_q - b_q;
        ialu_pkg::KIND_MUL: fin_res = p_acc[ialu_pkg::W-1:0];
        ialu_pkg::KIND_DIV: fin_res = neg_q ? (~w_q + 1'b1) : w_q;
        ialu_pkg::KIND_POW: fin_res = r_q;
        default:            fin_res = '0;
      endcase
    end
  end

  // multiply kind reuses the acc multiplier, so r_q holds operand b there
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      st_q   <= st_d;
      a_q    <= operand_a_i;
      b_q    <= operand_b_i;
      w_q    <= abs_a;
      d_q    <= abs_b;
      neg_q  <= operand_a_i[ialu_pkg::W-1] ^ operand_b_i[ialu_pkg::W-1];
      if (kind_i == ialu_pkg::KIND_POW) begin
        r_q <= ialu_pkg::W'(1);
      end else if (kind_i == ialu_pkg::KIND_MUL) begin
        r_q <= operand_b_i;
      end else begin
        r_q <= '0;
      end
    end else if (cmd_i.div_step) begin
      r_q <= ge ? diff[ialu_pkg::W-1:0] : rs;
      w_q <= {w_q[ialu_pkg::W-2:0], ge};
    end else if (cmd_i.pow_step) begin
      if (b_q[0]) begin
        r_q <= p_acc[ialu_pkg::W-1:0];
      end
      a_q <= p_sq[ialu_pkg::W-1:0];
      b_q <= {1'b0, b_q[ialu_pkg::W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_o <= ialu_pkg::ST_OK;
    end else if (cmd_i.fin) begin
      status_o <= st_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      res_q <= fin_res;
    end
  end

  assign result_o        = res_q;
  assign stat_o.kind     = kind_q;
  assign stat_o.err      = (st_q != ialu_pkg::ST_OK);
  assign stat_o.exp_zero = (b_q == '0);

endmodule

// ===== sv/ialu_ctrl.sv =====
// controller: sequences load, iteration steps, finish and result strobe
module ialu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  ialu_pkg::stat_t stat_i,
  output ialu_pkg::cmd_t  cmd_o,
  output logic            busy,
  output logic            done_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                 state_q, state_d;
  logic [ialu_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (stat_i.err || (stat_i.kind != ialu_pkg::KIND_DIV &&
                                    stat_i.kind != ialu_pkg::KIND_POW)) begin
          cmd_o.fin = 1'b1;
          state_d   = S_OUT;
        end else if (stat_i.kind == ialu_pkg::KIND_DIV) begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
          if (cnt_q == ialu_pkg::CNT_W'(ialu_pkg::W - 1)) begin
            state_d = S_FIN;
          end
        end else if (stat_i.exp_zero) begin
          cmd_o.fin = 1'b1;
          state_d   = S_OUT;
        end else begin
          cmd_o.pow_step = 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);

endmodule

// ===== sv/integer_alu_with_power_top.sv =====
// top level of the integer alu with add, sub, mul, signed div and power
//
//  channel  ports                                   beat taken when
//  ------   -------------------------------------   ------------------
//  in       start, busy, kind_i, operand_a_i/b_i     start && !busy
//  out      done_o, result_o, status_o               done_o (one cycle)
//
// add, sub, mul and every error finish without iteration steps
// divide: runs the restoring divider loop, one quotient bit per cycle
// power: one step per bit of the exponent's bit length n (at most 31),
// one square-and-multiply step per cycle
// async active-low reset returns the controller to idle
// results stay registered until the next operation finishes, the receiver cannot stall
module integer_alu_with_power_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               done_o,
  output logic signed [31:0] result_o,
  output logic [1:0]         status_o
);

  ialu_pkg::cmd_t               cmd;
  ialu_pkg::stat_t              stat;
  logic [ialu_pkg::W-1:0]       res;

  ialu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  ialu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .kind_i      (kind_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .stat_o      (stat),
    .result_o    (res),
    .status_o    (status_o)
  );

  assign result_o = $signed(res);

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("strobe outside busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted beat not held busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ialu_pkg::ST_OK) |-> (result_o == '0))
    else $error("error result not zero");

endmodule
